>>> rtl/core/bfg_pkg.sv
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared constants, register indexes and controller/datapath link types for
// the grayscale bilateral filter.
// ----------------------------------------------------------------------------
package bfg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SSCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RSCALE  = 3'd4;

    localparam int MAX_HEIGHT  = 4096;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;

    localparam int EXP_ENTRIES = 256;
    localparam int EXP_IDX_W   = 8;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

    localparam int SPATIAL_SHIFT = 11;
    localparam int RANGE_SHIFT   = 19;

    typedef struct packed {
        logic busy;
        logic step;
        logic centre_rd;
        logic centre_lat;
        logic tap_rd;
        logic tap_data;
        logic tap_sq;
        logic tap_rng;
        logic tap_lut;
        logic tap_wgt;
        logic tap_acc;
        logic div_init;
        logic div_step;
        logic finish;
    } bfg_cmd_t;

    typedef struct packed {
        logic need_out;
        logic last_tap;
        logic div_last;
        logic out_free;
    } bfg_stat_t;

endpackage

>>> rtl/core/bfg_ctrl.sv
// ----------------------------------------------------------------------------
// bfg_ctrl
// Sequencer: store write per request, then taps and divide if a result is due.
// ----------------------------------------------------------------------------
module bfg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bfg_pkg::bfg_stat_t  stat,
    output bfg_pkg::bfg_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_CADDR,
        S_CDATA,
        S_TADDR,
        S_TDATA,
        S_TSQ,
        S_TRNG,
        S_TLUT,
        S_TWGT,
        S_TACC,
        S_DINIT,
        S_DSTEP,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_STEP;
            S_STEP:  state_next = stat.need_out ? S_CADDR : S_IDLE;
            S_CADDR: state_next = S_CDATA;
            S_CDATA: state_next = S_TADDR;
            S_TADDR: state_next = S_TDATA;
            S_TDATA: state_next = S_TSQ;
            S_TSQ:   state_next = S_TRNG;
            S_TRNG:  state_next = S_TLUT;
            S_TLUT:  state_next = S_TWGT;
            S_TWGT:  state_next = S_TACC;
            S_TACC:  state_next = stat.last_tap ? S_DINIT : S_TADDR;
            S_DINIT: state_next = S_DSTEP;
            S_DSTEP: if (stat.div_last) state_next = S_FIN;
            S_FIN:   if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.busy       = (state_reg != S_IDLE);
        cmd.step       = (state_reg == S_STEP);
        cmd.centre_rd  = (state_reg == S_CADDR);
        cmd.centre_lat = (state_reg == S_CDATA);
        cmd.tap_rd     = (state_reg == S_TADDR);
        cmd.tap_data   = (state_reg == S_TDATA);
        cmd.tap_sq     = (state_reg == S_TSQ);
        cmd.tap_rng    = (state_reg == S_TRNG);
        cmd.tap_lut    = (state_reg == S_TLUT);
        cmd.tap_wgt    = (state_reg == S_TWGT);
        cmd.tap_acc    = (state_reg == S_TACC);
        cmd.div_init   = (state_reg == S_DINIT);
        cmd.div_step   = (state_reg == S_DSTEP);
        cmd.finish     = (state_reg == S_FIN) && stat.out_free;
    end

endmodule

>>> rtl/core/bfg_dp.sv
// ----------------------------------------------------------------------------
// bfg_dp
// Datapath: config registers, line store, raster counters, tap weight unit,
// accumulators, restoring divider and result register.
// ----------------------------------------------------------------------------
module bfg_dp #(
    parameter int MAX_RADIUS  = 4,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfg_pkg::bfg_cmd_t                 cmd,
    output bfg_pkg::bfg_stat_t                stat,
    input  logic                              accept,
    input  logic                              func,
    input  logic [PIXEL_BITS-1:0]             pixel_in,
    input  logic                              cfg_we,
    input  logic [bfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic [PIXEL_BITS-1:0]             pixel_out,
    output logic [bfg_pkg::ROW_W-1:0]         out_row,
    output logic [bfg_pkg::COL_W-1:0]         out_col,
    output logic                              frame_end
);

    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HW    = bfg_pkg::HEIGHT_W;
    localparam int RWW   = bfg_pkg::ROW_W;
    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int POS_W = $clog2(bfg_pkg::MAX_HEIGHT * MAX_WIDTH) + 2;
    localparam int D2W   = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int SPW   = D2W + 16;
    localparam int PB    = PIXEL_BITS;
    localparam int RPW   = 2 * PB + 24;
    localparam int GW    = WEIGHT_BITS + 1;
    localparam int TAPS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int LT    = $clog2(TAPS + 1);
    localparam int NUMW  = GW + PB + LT;
    localparam int DENW  = GW + LT;
    localparam int RMW   = NUMW + 1;
    localparam int CNW   = $clog2(PB + 1);
    localparam int NE    = bfg_pkg::EXP_ENTRIES;

    function automatic logic [NE*GW-1:0] build_exp();
        logic [127:0]       v;
        logic [127:0]       e;
        logic [NE*GW-1:0]   t;
        v = 128'd1 << 32;
        t = '0;
        for (int k = 0; k < NE; k++)
        begin
            e = (v + (128'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
            t[k*GW +: GW] = e[GW-1:0];
            v = (v * {64'd0, bfg_pkg::EXP_STEP_Q32} + (128'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam logic [NE*GW-1:0] EXP_TBL = build_exp();

    // configuration
    logic [2:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] sscale_reg;
    logic [23:0] rscale_reg;
    logic        geom_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd2;
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            sscale_reg <= 16'd8192;
            rscale_reg <= 24'd8389;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfg_pkg::REG_RADIUS: radius_reg <= cfg_data[2:0];
                bfg_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                bfg_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                bfg_pkg::REG_SSCALE: sscale_reg <= cfg_data[15:0];
                bfg_pkg::REG_RSCALE: rscale_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign geom_wr = cfg_we && (cfg_index == bfg_pkg::REG_RADIUS ||
                                cfg_index == bfg_pkg::REG_WIDTH  ||
                                cfg_index == bfg_pkg::REG_HEIGHT);

    logic [RW-1:0] eff_r;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb
    begin
        eff_r = (radius_reg > 3'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        if (width_reg == 11'd0)
            eff_w = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg == 13'd0)
            eff_h = HW'(1);
        else if (32'(height_reg) > bfg_pkg::MAX_HEIGHT)
            eff_h = HW'(bfg_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    logic [POS_W-1:0] total_reg;
    logic [POS_W-1:0] lag_reg;

    always_ff @(posedge clk)
    begin
        total_reg <= POS_W'(eff_w) * POS_W'(eff_h);
        lag_reg   <= POS_W'(eff_r) * POS_W'(eff_w) + POS_W'(eff_r);
    end

    // request payload
    logic          func_reg;
    logic [PB-1:0] pix_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            pix_reg  <= pixel_in;
        end
    end

    // raster counters
    logic [POS_W-1:0] in_pos_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic [CW-1:0]    in_col_reg;
    logic [SW-1:0]    in_slot_reg;
    logic [CW-1:0]    out_col_reg;
    logic [RWW-1:0]   out_row_reg;
    logic [SW-1:0]    out_slot_reg;
    logic             in_frame;
    logic             past_lag;
    logic             out_last;

    assign in_frame = (in_pos_reg < total_reg);
    assign past_lag = (in_pos_reg >= lag_reg);
    assign out_last = (out_pos_reg == total_reg - POS_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (geom_wr || (cmd.step && past_lag && !(out_pos_reg < total_reg)) ||
                 (cmd.finish && out_last))
        begin
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                in_pos_reg <= in_pos_reg + POS_W'(1);
                if ((CW+1)'(in_col_reg) == (CW+1)'(eff_w) - (CW+1)'(1))
                begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (in_slot_reg == SW'(SLOTS - 1)) ? '0
                                                                   : in_slot_reg + SW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_pos_reg <= out_pos_reg + POS_W'(1);
                if ((CW+1)'(out_col_reg) == (CW+1)'(eff_w) - (CW+1)'(1))
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + RWW'(1);
                    out_slot_reg <= (out_slot_reg == SW'(SLOTS - 1)) ? '0
                                                                     : out_slot_reg + SW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // window tap walk
    logic signed [RW:0]  dx_reg;
    logic signed [RW:0]  dy_reg;
    logic [SW-1:0]       tslot_reg;
    logic signed [RW:0]  r_pos;
    logic signed [RW:0]  r_neg;
    logic signed [CW+1:0]  tc;
    logic signed [RWW+1:0] tr;
    logic                tap_ok;
    logic [RW-1:0]       adx;
    logic [RW-1:0]       ady;
    logic [SW:0]         slot_sum;
    logic [SW-1:0]       slot_first;

    assign r_pos = $signed({1'b0, eff_r});
    assign r_neg = -r_pos;
    assign tc = $signed({2'b00, out_col_reg}) + (CW+2)'(dx_reg);
    assign tr = $signed({2'b00, out_row_reg}) + (RWW+2)'(dy_reg);
    assign tap_ok = !tc[CW+1] && (tc[CW:0] < (CW+1)'(eff_w)) &&
                    !tr[RWW+1] && (tr[RWW:0] < (RWW+1)'(eff_h));
    assign adx = dx_reg[RW] ? RW'(-dx_reg) : RW'(dx_reg);
    assign ady = dy_reg[RW] ? RW'(-dy_reg) : RW'(dy_reg);
    assign slot_sum = (SW+1)'(out_slot_reg) + (SW+1)'(SLOTS) - (SW+1)'(eff_r);
    assign slot_first = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                                     : SW'(slot_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.centre_rd)
        begin
            dx_reg    <= r_neg;
            dy_reg    <= r_neg;
            tslot_reg <= slot_first;
        end
        else if (cmd.tap_acc)
        begin
            if (dx_reg == r_pos)
            begin
                dx_reg    <= r_neg;
                dy_reg    <= dy_reg + (RW+1)'(1);
                tslot_reg <= (tslot_reg == SW'(SLOTS - 1)) ? '0 : tslot_reg + SW'(1);
            end
            else
            begin
                dx_reg <= dx_reg + (RW+1)'(1);
            end
        end
    end

    // line store, one write and one registered read port
    logic [PB-1:0] mem [DEPTH];
    logic [PB-1:0] rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign wr_en   = cmd.step && in_frame;
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_en   = cmd.centre_rd || (cmd.tap_rd && tap_ok);
    assign rd_addr = cmd.centre_rd ? AW'(out_slot_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg)
                                   : AW'(tslot_reg) * AW'(MAX_WIDTH) + AW'(tc[CW-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= func_reg ? '0 : pix_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // tap weight unit
    logic [PB-1:0]    centre_reg;
    logic             tap_valid_reg;
    logic [D2W-1:0]   d2_reg;
    logic [PB-1:0]    p_reg;
    logic [PB-1:0]    dp_reg;
    logic [SPW-1:0]   sprod_reg;
    logic [2*PB-1:0]  dp2_reg;
    logic [RPW-1:0]   rprod_reg;
    logic [GW-1:0]    gs_reg;
    logic [GW-1:0]    gr_reg;
    logic [GW-1:0]    w_reg;
    logic [SPW:0]     sidx;
    logic [RPW:0]     ridx;
    logic [GW-1:0]    gs_lut;
    logic [GW-1:0]    gr_lut;
    logic [2*GW:0]    wprod;

    assign sidx = ((SPW+1)'(sprod_reg) + (SPW+1)'(1 << (bfg_pkg::SPATIAL_SHIFT - 1)))
                  >> bfg_pkg::SPATIAL_SHIFT;
    assign ridx = ((RPW+1)'(rprod_reg) + (RPW+1)'(1 << (bfg_pkg::RANGE_SHIFT - 1)))
                  >> bfg_pkg::RANGE_SHIFT;
    assign gs_lut = (sidx < (SPW+1)'(NE))
                    ? EXP_TBL[int'(sidx[bfg_pkg::EXP_IDX_W-1:0])*GW +: GW] : '0;
    assign gr_lut = (ridx < (RPW+1)'(NE))
                    ? EXP_TBL[int'(ridx[bfg_pkg::EXP_IDX_W-1:0])*GW +: GW] : '0;
    assign wprod = ((2*GW+1)'(gs_reg) * (2*GW+1)'(gr_reg) +
                    (2*GW+1)'(1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.centre_lat)
            centre_reg <= rd_data_reg;
        if (cmd.tap_rd)
        begin
            tap_valid_reg <= tap_ok;
            d2_reg <= D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);
        end
        if (cmd.tap_data)
        begin
            p_reg     <= rd_data_reg;
            dp_reg    <= (rd_data_reg > centre_reg) ? rd_data_reg - centre_reg
                                                    : centre_reg - rd_data_reg;
            sprod_reg <= SPW'(d2_reg) * SPW'(sscale_reg);
        end
        if (cmd.tap_sq)
        begin
            dp2_reg <= (2*PB)'(dp_reg) * (2*PB)'(dp_reg);
            gs_reg  <= gs_lut;
        end
        if (cmd.tap_rng)
            rprod_reg <= RPW'(dp2_reg) * RPW'(rscale_reg);
        if (cmd.tap_lut)
            gr_reg <= gr_lut;
        if (cmd.tap_wgt)
            w_reg <= wprod[GW-1:0];
    end

    // accumulators and divider
    logic [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic [RMW-1:0]  rem_reg;
    logic [RMW-1:0]  dsh_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [PB-1:0]   quot_reg;
    logic            fit;

    assign fit = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.centre_rd)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.tap_acc && tap_valid_reg)
        begin
            num_reg <= num_reg + NUMW'(w_reg) * NUMW'(p_reg);
            den_reg <= den_reg + DENW'(w_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg <= RMW'(num_reg) + RMW'(den_reg >> 1);
            dsh_reg <= RMW'(den_reg) << (PB - 1);
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fit)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[PB-2:0], fit};
            cnt_reg  <= cnt_reg + CNW'(1);
        end
    end

    // result register
    logic result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.finish)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            pixel_out <= quot_reg;
            out_row   <= out_row_reg;
            out_col   <= bfg_pkg::COL_W'(out_col_reg);
            frame_end <= out_last;
        end
    end

    assign result_valid  = result_valid_reg;
    assign stat.need_out = past_lag && (out_pos_reg < total_reg);
    assign stat.last_tap = (dx_reg == r_pos) && (dy_reg == r_pos);
    assign stat.div_last = (cnt_reg == CNW'(PB - 1));
    assign stat.out_free = !result_valid_reg || !result_stall;

endmodule

>>> rtl/core/bilateral_filter_gray.sv
// ----------------------------------------------------------------------------
// bilateral_filter_gray
// Bilateral filter for a raster-order grayscale pixel stream.
// ----------------------------------------------------------------------------
// A pixel request that yields no result returns to idle after its step. For
// one that yields a result, one shared tap unit walks the window one tap at
// a time through the single read port of the line store, in address, data,
// square, range, lookup, weight and accumulate steps per tap, then a
// restoring divider produces one quotient bit per cycle; a stalled result
// holds the finish state. Results trail the input by R rows plus R pixels;
// flush requests (func = 1) push the tail of the frame out. The line store
// is not cleared after reset; only positions written in the current frame
// are ever read. Writing radius, width or height restarts the frame.
module bilateral_filter_gray #(
    parameter int MAX_RADIUS  = 4,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              func,
    input  logic [PIXEL_BITS-1:0]             pixel_in,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [PIXEL_BITS-1:0]             pixel_out,
    output logic [bfg_pkg::ROW_W-1:0]         out_row,
    output logic [bfg_pkg::COL_W-1:0]         out_col,
    output logic                              frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bfg_pkg::bfg_cmd_t  cmd;
    bfg_pkg::bfg_stat_t stat;
    logic               accept;

    assign item_stall = cmd.busy;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    bfg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .cmd    (cmd)
    );

    bfg_dp #(
        .MAX_RADIUS  (MAX_RADIUS),
        .MAX_WIDTH   (MAX_WIDTH),
        .PIXEL_BITS  (PIXEL_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .accept       (accept),
        .func         (func),
        .pixel_in     (pixel_in),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_end    (frame_end)
    );

    // the block is busy in the cycle after it takes a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("block not busy after accepting a request");

    // a result only appears at the end of work on a request
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result raised while idle");

    // the sequencer never loads a result over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!result_valid || !result_stall))
        else $error("result overwritten while stalled");

endmodule

>>> test/bilateral_filter_gray_tb.sv
// ----------------------------------------------------------------------------
// bilateral_filter_gray_tb
// Self-checking bench for the grayscale bilateral filter: small frames under
// many geometry and scale settings, each result checked against a local
// fixed-point model of the window filter, with random gaps and stalls.
// ----------------------------------------------------------------------------
module bilateral_filter_gray_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RADIUS  = 4;
    localparam int N_WIDTH   = 1024;
    localparam int ROW_SLOTS = 2 * N_RADIUS + 2;
    localparam int WGT_BITS  = 12;
    localparam logic [bfg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 800;

    typedef enum logic {FN_PIXEL = 1'b0, FN_FLUSH = 1'b1} func_e;

    typedef struct packed {
        func_e      fn;
        logic [7:0] pix;
    } pix_req_t;

    typedef struct packed {
        logic [7:0]                pix;
        logic [bfg_pkg::ROW_W-1:0] row;
        logic [bfg_pkg::COL_W-1:0] col;
        logic                      fend;
    } filt_px_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic func = 1'b0;
    logic [7:0] pixel_in = 8'd0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [7:0] pixel_out;
    logic [bfg_pkg::ROW_W-1:0] out_row;
    logic [bfg_pkg::COL_W-1:0] out_col;
    logic frame_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bfg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bfg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bilateral_filter_gray dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .func(func), .pixel_in(pixel_in),
        .result_valid(result_valid), .result_stall(result_stall),
        .pixel_out(pixel_out), .out_row(out_row), .out_col(out_col),
        .frame_end(frame_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // local copy of filter state
    logic [12:0] exp_lut [bfg_pkg::EXP_ENTRIES];
    logic [7:0]  lines [ROW_SLOTS*N_WIDTH];
    logic [2:0]  m_radius = 3'd2;
    logic [10:0] m_width = 11'd1024;
    logic [12:0] m_height = 13'd1024;
    logic [15:0] m_sscale = 16'd8192;
    logic [23:0] m_rscale = 24'd8389;
    int unsigned in_pos = 0, out_pos = 0;

    pix_req_t pending_px[$];
    filt_px_t filtered_q[$];

    int gap_left = 0, stall_left = 0;
    bit quiet_mode = 0;
    int mismatches = 0, n_results = 0, n_frames = 0, n_pixels = 0, n_flushes = 0;
    int idle_cycles = 0;

    function automatic int eff_r();
        return (m_radius > N_RADIUS) ? N_RADIUS : m_radius;
    endfunction

    function automatic int eff_w();
        if (m_width == 0) return 1;
        return (m_width > N_WIDTH) ? N_WIDTH : m_width;
    endfunction

    function automatic int eff_h();
        if (m_height == 0) return 1;
        return (m_height > bfg_pkg::MAX_HEIGHT) ? bfg_pkg::MAX_HEIGHT : m_height;
    endfunction

    function automatic logic [63:0] lut_at(logic [63:0] idx);
        return (idx < bfg_pkg::EXP_ENTRIES) ? 64'(exp_lut[idx[7:0]]) : 64'd0;
    endfunction

    function automatic logic [7:0] px_at(int r, int c);
        return lines[(r % ROW_SLOTS) * N_WIDTH + (c % N_WIDTH)];
    endfunction

    function automatic logic [7:0] smooth_at(int r, int c, int rad, int w, int h);
        logic [63:0] num, den, d2, dp, gs, gr, wt;
        logic [7:0] ctr, p;
        num = 0;
        den = 0;
        ctr = px_at(r, c);
        for (int dy = -rad; dy <= rad; dy++) begin
            if (r + dy < 0 || r + dy >= h) continue;
            for (int dx = -rad; dx <= rad; dx++) begin
                if (c + dx < 0 || c + dx >= w) continue;
                p  = px_at(r + dy, c + dx);
                d2 = 64'(dx * dx + dy * dy);
                dp = (p > ctr) ? 64'(p - ctr) : 64'(ctr - p);
                gs = lut_at((d2 * m_sscale + 64'd1024) >> bfg_pkg::SPATIAL_SHIFT);
                gr = lut_at((dp * dp * m_rscale + 64'd262144) >> bfg_pkg::RANGE_SHIFT);
                wt = (gs * gr + 64'd2048) >> WGT_BITS;
                num += wt * p;
                den += wt;
            end
        end
        if (den == 0) return ctr;
        return 8'((num + den / 2) / den);
    endfunction

    // advance the local filter by one accepted request
    function automatic void step_filter(pix_req_t rq);
        int w, h, rad, total, lag, r, c;
        filt_px_t res;
        w = eff_w();
        h = eff_h();
        rad = eff_r();
        total = w * h;
        lag = rad * w + rad;
        if (in_pos < total)
            lines[((in_pos / w) % ROW_SLOTS) * N_WIDTH + in_pos % w] =
                (rq.fn == FN_FLUSH) ? 8'd0 : rq.pix;
        in_pos++;
        if (in_pos <= lag) return;
        if (out_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
            return;
        end
        r = out_pos / w;
        c = out_pos % w;
        res.pix  = smooth_at(r, c, rad, w, h);
        res.row  = bfg_pkg::ROW_W'(r);
        res.col  = bfg_pkg::COL_W'(c);
        res.fend = (out_pos == total - 1);
        filtered_q.push_back(res);
        out_pos++;
        if (res.fend) begin
            in_pos = 0;
            out_pos = 0;
        end
    endfunction

    function automatic int draw_wait();
        if (quiet_mode) return 0;
        return $urandom_range(0, 7);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            gap_left = 0;
        end else begin
            bit nv;
            nv = item_valid;
            if (item_valid && !item_stall) begin
                step_filter(pending_px.pop_front());
                nv = 0;
                gap_left = draw_wait();
            end
            if (!nv) begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_px.size() > 0) begin
                    func <= pending_px[0].fn;
                    pixel_in <= pending_px[0].pix;
                    nv = 1;
                end
            end
            item_valid <= nv;
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_valid && !result_stall) begin
                filt_px_t exp_px;
                n_results++;
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pix=%0d row=%0d col=%0d fend=%0b",
                                 pixel_out, out_row, out_col, frame_end);
                end else begin
                    exp_px = filtered_q.pop_front();
                    if (exp_px.fend) n_frames++;
                    if (pixel_out !== exp_px.pix || out_row !== exp_px.row ||
                        out_col !== exp_px.col || frame_end !== exp_px.fend) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp pix=%0d row=%0d col=%0d fend=%0b, %s%0d %0d %0d %0b",
                                     exp_px.pix, exp_px.row, exp_px.col, exp_px.fend,
                                     "got ", pixel_out, out_row, out_col, frame_end);
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                stall_left--;
                result_stall <= 1'b1;
            end else
                result_stall <= 1'b0;
            if (($urandom_range(0, 299)) == 0) quiet_mode = !quiet_mode;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else if (rst_n) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding", filtered_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [bfg_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bfg_pkg::REG_RADIUS: begin m_radius = val[2:0]; in_pos = 0; out_pos = 0; end
            bfg_pkg::REG_WIDTH:  begin m_width = val[10:0]; in_pos = 0; out_pos = 0; end
            bfg_pkg::REG_HEIGHT: begin m_height = val[12:0]; in_pos = 0; out_pos = 0; end
            bfg_pkg::REG_SSCALE: m_sscale = val[15:0];
            bfg_pkg::REG_RSCALE: m_rscale = val;
            default: ;
        endcase
    endtask

    // hold the sender until every outstanding result is back
    task automatic wait_idle();
        while (pending_px.size() > 0 || item_valid || filtered_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic geometry(int rad, int w, int h);
        reg_write(bfg_pkg::REG_RADIUS, 24'(rad));
        reg_write(bfg_pkg::REG_WIDTH, 24'(w));
        reg_write(bfg_pkg::REG_HEIGHT, 24'(h));
    endtask

    task automatic push_px(func_e fn, logic [7:0] pix);
        pix_req_t rq;
        rq.fn = fn;
        rq.pix = pix;
        pending_px.push_back(rq);
        if (fn == FN_PIXEL) n_pixels++; else n_flushes++;
    endtask

    // a frame with random content, its flush tail, sometimes cut short
    task automatic queue_frame(bit cut);
        int w, h, rad, total, lag, n;
        w = eff_w();
        h = eff_h();
        rad = eff_r();
        total = w * h;
        lag = rad * w + rad;
        n = cut ? $urandom_range(1, total + lag) : total + lag;
        for (int i = 0; i < n; i++) begin
            if (i < total)
                push_px(($urandom_range(0, 19) == 0) ? FN_FLUSH : FN_PIXEL, 8'($urandom));
            else
                push_px(($urandom_range(0, 9) == 0) ? FN_PIXEL : FN_FLUSH, 8'($urandom));
        end
    endtask

    function automatic logic [15:0] pick_sscale();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1024, 16384));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_rscale();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1000, 40000));
            3: return 24'($urandom_range(40000, 2000000));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [63:0] v;
        v = 64'd1 << 32;
        for (int k = 0; k < bfg_pkg::EXP_ENTRIES; k++) begin
            exp_lut[k] = 13'((v + (64'd1 << (31 - WGT_BITS))) >> (32 - WGT_BITS));
            v = (v * bfg_pkg::EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < ROW_SLOTS * N_WIDTH; i++) lines[i] = 8'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 3x3 image, radius 1, extremes and an in-frame flush
        geometry(1, 3, 3);
        reg_write(bfg_pkg::REG_SSCALE, 24'd8192);
        reg_write(bfg_pkg::REG_RSCALE, 24'd8389);
        reg_write(REG_SPARE, 24'hFFFFFF);
        push_px(FN_PIXEL, 8'd0);
        push_px(FN_PIXEL, 8'd255);
        push_px(FN_PIXEL, 8'd0);
        push_px(FN_PIXEL, 8'd255);
        push_px(FN_FLUSH, 8'd170);
        push_px(FN_PIXEL, 8'd85);
        push_px(FN_PIXEL, 8'd128);
        push_px(FN_PIXEL, 8'd127);
        push_px(FN_PIXEL, 8'd1);
        push_px(FN_PIXEL, 8'd200);
        push_px(FN_PIXEL, 8'd77);
        push_px(FN_FLUSH, 8'd0);
        push_px(FN_FLUSH, 8'd0);
        wait_idle();

        // zero size acts as a single pixel, radius above the limit clamps
        geometry(0, 0, 0);
        reg_write(bfg_pkg::REG_SSCALE, 24'hFFFF);
        reg_write(bfg_pkg::REG_RSCALE, 24'hFFFFFF);
        push_px(FN_PIXEL, 8'd255);
        push_px(FN_PIXEL, 8'd9);
        wait_idle();
        geometry(7, 4, 2);
        reg_write(bfg_pkg::REG_SSCALE, 24'd0);
        reg_write(bfg_pkg::REG_RSCALE, 24'd0);
        queue_frame(0);
        wait_idle();

        // widest and tallest settings, first with no window lag, frames left unfinished
        geometry(0, 2047, 1);
        for (int i = 0; i < 6; i++) push_px(FN_PIXEL, 8'($urandom));
        wait_idle();
        geometry(0, 1, 8191);
        for (int i = 0; i < 6; i++) push_px(FN_PIXEL, 8'($urandom));
        wait_idle();
        geometry(4, 1024, 4096);
        reg_write(bfg_pkg::REG_SSCALE, 24'd8192);
        reg_write(bfg_pkg::REG_RSCALE, 24'd8389);
        for (int i = 0; i < 8; i++) push_px(FN_PIXEL, 8'($urandom));
        wait_idle();

        // random frames under random settings
        while (n_pixels + n_flushes < 500) begin
            int rad, w, h;
            rad = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
            geometry(rad, w, h);
            if ($urandom_range(0, 1)) reg_write(bfg_pkg::REG_SSCALE, 24'(pick_sscale()));
            if ($urandom_range(0, 1)) reg_write(bfg_pkg::REG_RSCALE, pick_rscale());
            repeat ($urandom_range(1, 2)) queue_frame($urandom_range(0, 7) == 0);
            wait_idle();
        end

        $display("sent %0d pixels and %0d flush requests, checked %0d results over %0d frames",
                 n_pixels, n_flushes, n_results, n_frames);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
